// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes, the data width and the control bundle that the
// queue controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic              wr_back;
        logic [DATA_W-1:0] value;
    } t_chain_op;

endpackage

// File: rtl/deq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue storage cell
// One slot of the shifting chain; it moves towards the back on a front push,
// towards the front on a front pop, and loads on a back push into its slot.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                         i_clk,
    input  deq_pkg::t_chain_op           i_op,
    input  logic [CW-1:0]                i_count,
    input  logic [deq_pkg::DATA_W-1:0]   i_left_data,
    input  logic [deq_pkg::DATA_W-1:0]   i_right_data,
    output logic [deq_pkg::DATA_W-1:0]   o_data,
    output logic [deq_pkg::DATA_W-1:0]   o_last_data
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              is_free;
    logic              is_last;

    assign is_free = (i_count == CW'(IDX));
    assign is_last = (i_count == CW'(IDX + 1));

    always_comb begin
        n_data = r_data;
        if (i_op.shift_up) begin
            n_data = i_left_data;
        end else if (i_op.shift_down) begin
            n_data = i_right_data;
        end else if (i_op.wr_back && is_free) begin
            n_data = i_op.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_last_data = is_last ? r_data : '0;

endmodule

// File: rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Fixed-capacity deque held in a chain of shifting cells, front at cell zero.
// ----------------------------------------------------------------------------
// The result of an accepted request is registered in the output register in the
// cycle after it. Throughput: one request per cycle while the output is taken;
// the output register frees as it is taken.
// Reset clears the entry count and the output valid flag; cell contents are
// left as they are and are never read before being written.
module double_ended_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // push_value[31:0]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((deq_pkg::DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                        m_axis_tdata,   // pop_value[31:0], held_count, zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import deq_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic [DATA_W-1:0] r_pop;
    logic [DATA_W-1:0] n_pop;
    logic [CW-1:0]     r_held;

    logic              fire;
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] back_data;
    t_chain_op         op;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] last_data [DEPTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign full          = (r_count == CW'(DEPTH));
    assign empty         = (r_count == '0);

    always_comb begin
        op.value      = s_axis_tdata;
        op.shift_up   = fire && (s_axis_tuser == CMD_PUSH_FRONT) && !full;
        op.wr_back    = fire && (s_axis_tuser == CMD_PUSH_BACK) && !full;
        op.shift_down = fire && (s_axis_tuser == CMD_POP_FRONT) && !empty;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            deq_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_op         (op),
                .i_count      (r_count),
                .i_left_data  ((g == 0) ? s_axis_tdata : cell_data[(g == 0) ? 0 : g - 1]),
                .i_right_data ((g == DEPTH - 1) ? '0 :
                               cell_data[(g == DEPTH - 1) ? g : g + 1]),
                .o_data       (cell_data[g]),
                .o_last_data  (last_data[g])
            );
        end
    endgenerate

    always_comb begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_data = back_data | last_data[i];
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = STATUS_DONE;
        n_pop    = '0;
        unique case (s_axis_tuser) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = STATUS_OVERFLOW;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = STATUS_UNDERFLOW;
                end else begin
                    n_pop   = cell_data[0];
                    n_count = r_count - CW'(1);
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = STATUS_UNDERFLOW;
                end else begin
                    n_pop   = back_data;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_status = STATUS_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
            r_pop    <= n_pop;
            r_held   <= n_count;
        end
    end

    always_comb begin
        m_axis_tdata               = '0;
        m_axis_tdata[DATA_W-1:0]   = r_pop;
        m_axis_tdata[DATA_W +: CW] = r_held;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == STATUS_OVERFLOW)) |-> (r_held == CW'(DEPTH)))
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == STATUS_UNDERFLOW)) |-> (r_held == '0 && r_pop == '0))
        else $error("underflow reported while entries held");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ((s_axis_tuser == CMD_PUSH_FRONT) || (s_axis_tuser == CMD_PUSH_BACK))
         && !full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted push did not grow the count");

endmodule
